>>> sv/mll_pkg.sv
// Shared types, constants and saturation helpers for the four-pole ladder lowpass.
// Depends on nothing; every other file of the block imports it.

package mll_pkg;

   // Datapath widths.
   localparam int STAGES    = 4;
   localparam int SMP_W     = 16;   // audio word, Q1.15
   localparam int ST_W      = 24;   // stage state, Q4.20
   localparam int SUM_W     = 28;   // headroom for sums before saturation
   localparam int OUT_RND_W = 20;   // stage value after dropping five fraction bits
   localparam int CUT_W     = 15;
   localparam int RES_W     = 16;
   localparam int F_W       = 16;   // scaled cutoff and its square
   localparam int T_W       = 14;   // feedback curve term
   localparam int FB_W      = 16;   // feedback gain, Q.14
   localparam int G_W       = 15;   // input gain, Q.15
   localparam int K_W       = 17;   // stage pole coefficient, signed Q.15

   // Cycles spent in the settle state; the last one starts the input stage, and the
   // coefficient pipeline is four registers deep.
   localparam int SETTLE_CYCLES = 5;
   localparam int SETTLE_CNT_W  = $clog2(SETTLE_CYCLES);

   // Fixed-point coefficients.
   localparam logic [16:0]        K_FSCALE  = 17'd76022;  // 1.16 in Q.16
   localparam logic [13:0]        K_FBCURVE = 14'd9830;   // 0.15 in Q.16
   localparam logic [14:0]        K_GAIN    = 15'd22946;  // 0.35013 in Q.16
   localparam logic signed [15:0] K_PREV    = 16'sd9830;  // 0.3 in Q.15

   // Register file.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CUT_W-1:0] CUTOFF_RESET    = 15'd8192;
   localparam logic [RES_W-1:0] RESONANCE_RESET = 16'd0;

   typedef enum logic {
      CSR_CUTOFF    = 1'b0,
      CSR_RESONANCE = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETTLE,
      ST_RUN,
      ST_HOLD
   } ctrl_state_type;

   // What one cell hands to its neighbor: a one-cycle token and the stage value.
   typedef struct packed {
      logic                    go;
      logic signed [ST_W-1:0]  value;
   } stage_link_type;

   typedef struct packed {
      logic        [FB_W-1:0] fb;
      logic        [G_W-1:0]  g;
      logic signed [K_W-1:0]  k;
   } coef_type;

   // Clamp a wide sum to the Q4.20 state range.
   function automatic logic signed [ST_W-1:0] sat_st(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-ST_W:0]     upper;
      logic signed [ST_W-1:0]  res;
      upper = v[SUM_W-1:ST_W-1];
      if ((&upper) || (~|upper)) begin
         res = v[ST_W-1:0];
      end else if (v[SUM_W-1]) begin
         res = {1'b1, {(ST_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(ST_W-1){1'b1}}};
      end
      return res;
   endfunction

   // Clamp a rounded stage value to the 16-bit audio range.
   function automatic logic signed [SMP_W-1:0] sat_out(
      input logic signed [OUT_RND_W-1:0] v);
      logic [OUT_RND_W-SMP_W:0] upper;
      logic signed [SMP_W-1:0]  res;
      upper = v[OUT_RND_W-1:SMP_W-1];
      if ((&upper) || (~|upper)) begin
         res = v[SMP_W-1:0];
      end else if (v[OUT_RND_W-1]) begin
         res = {1'b1, {(SMP_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(SMP_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

>>> sv/mll_req_if.sv
// Input channel of the ladder lowpass: valid/ready handshake and one audio word.
// Depends on mll_pkg for the word width.

interface mll_req_if;
   import mll_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [SMP_W-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

>>> sv/mll_rsp_if.sv
// Result channel of the ladder lowpass: valid/ready handshake and one audio word.
// Depends on mll_pkg for the word width.

interface mll_rsp_if;
   import mll_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [SMP_W-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

>>> sv/mll_coef.sv
// Coefficient pipeline: derives feedback gain, input gain and pole coefficient
// from the cutoff and resonance registers. Depends on mll_pkg.

module mll_coef (
   input  logic                        clock,
   input  logic [mll_pkg::CUT_W-1:0]   cutoff,
   input  logic [mll_pkg::RES_W-1:0]   resonance,
   output mll_pkg::coef_type           coef
);
   import mll_pkg::*;

   logic [31:0]            f_prod;
   logic [31:0]            f2_prod;
   logic [29:0]            t_prod;
   logic [31:0]            sq_prod;
   logic [15:0]            one_minus_t;
   logic [31:0]            fb_prod;
   logic [30:0]            g_prod;

   logic [F_W-1:0]         f_ff, f_in;
   logic [F_W-1:0]         f2_ff, f2_in;
   logic signed [K_W-1:0]  k_ff, k_in;
   logic [T_W-1:0]         t_ff, t_in;
   logic [F_W-1:0]         sq_ff, sq_in;
   logic [FB_W-1:0]        fb_ff, fb_in;
   logic [G_W-1:0]         g_ff, g_in;

   // Each product is rounded half up before it is registered.
   always_comb begin
      f_prod  = 32'(cutoff) * 32'(K_FSCALE) + 32'd32768;
      f_in    = f_prod[31:16];

      f2_prod = 32'(f_ff) * 32'(f_ff) + 32'd16384;
      f2_in   = f2_prod[30:15];
      k_in    = $signed(17'd32768) - $signed({1'b0, f_ff});

      t_prod  = 30'(f2_ff) * 30'(K_FBCURVE) + 30'd32768;
      t_in    = t_prod[29:16];
      sq_prod = 32'(f2_ff) * 32'(f2_ff) + 32'd16384;
      sq_in   = sq_prod[30:15];

      one_minus_t = 16'd32768 - 16'(t_ff);
      fb_prod = 32'(resonance) * 32'(one_minus_t) + 32'd16384;
      fb_in   = fb_prod[30:15];
      g_prod  = 31'(sq_ff) * 31'(K_GAIN) + 31'd32768;
      g_in    = g_prod[30:16];
   end

   always_ff @(posedge clock) begin
      f_ff  <= f_in;
      f2_ff <= f2_in;
      k_ff  <= k_in;
      t_ff  <= t_in;
      sq_ff <= sq_in;
      fb_ff <= fb_in;
      g_ff  <= g_in;
   end

   assign coef = '{fb: fb_ff, g: g_ff, k: k_ff};

endmodule

>>> sv/mll_front.sv
// Input stage: subtracts resonance feedback from the sample and applies the
// cutoff-dependent gain, then hands the result to the first cell. Depends on mll_pkg.

module mll_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              go,
   input  logic signed [mll_pkg::SMP_W-1:0]  sample,
   input  logic signed [mll_pkg::ST_W-1:0]   fb_tap,
   input  mll_pkg::coef_type                 coef,
   output mll_pkg::stage_link_type           link_out
);
   import mll_pkg::*;

   logic signed [40:0]       fb_prod;
   logic signed [SUM_W-1:0]  diff;
   logic signed [39:0]       ug_prod;

   logic signed [26:0]       fbp_ff, fbp_in;
   logic signed [ST_W-1:0]   u_ff, u_in;
   logic signed [ST_W-1:0]   val_ff, val_in;
   logic                     step_b_ff;
   logic                     step_c_ff;
   logic                     go_ff;

   always_comb begin
      fb_prod = 41'(fb_tap) * 41'($signed({1'b0, coef.fb})) + 41'sd8192;
      fbp_in  = fb_prod[40:14];

      diff    = (SUM_W'(sample) <<< 5) - SUM_W'(fbp_ff);
      u_in    = sat_st(diff);

      ug_prod = 40'(u_ff) * 40'($signed({1'b0, coef.g})) + 40'sd16384;
      val_in  = sat_st(SUM_W'($signed(ug_prod[39:15])));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_b_ff <= 1'b0;
         step_c_ff <= 1'b0;
         go_ff     <= 1'b0;
      end else begin
         step_b_ff <= go;
         step_c_ff <= step_b_ff;
         go_ff     <= step_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         fbp_ff <= fbp_in;
      end
      if (step_b_ff) begin
         u_ff <= u_in;
      end
      if (step_c_ff) begin
         val_ff <= val_in;
      end
   end

   assign link_out = '{go: go_ff, value: val_ff};

endmodule

>>> sv/mll_cell.sv
// One pole of the ladder: keeps its last input and output, and on each token
// computes y = x + 0.3*xprev + k*y, products first, then the sum. Depends on mll_pkg.

module mll_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  mll_pkg::stage_link_type          link_in,
   input  logic signed [mll_pkg::K_W-1:0]   k,
   output mll_pkg::stage_link_type          link_out
);
   import mll_pkg::*;

   logic signed [39:0]       pp_prod;
   logic signed [40:0]       po_prod;
   logic signed [SUM_W-1:0]  sum;

   logic signed [ST_W-1:0]   out_ff, out_in;
   logic signed [ST_W-1:0]   prev_ff;
   logic signed [24:0]       pp_ff, pp_in;
   logic signed [25:0]       po_ff, po_in;
   logic signed [ST_W-1:0]   x_ff;
   logic                     add_ff;
   logic                     go_ff;

   always_comb begin
      pp_prod = 40'(prev_ff) * 40'(K_PREV) + 40'sd16384;
      pp_in   = pp_prod[39:15];
      po_prod = 41'(out_ff) * 41'(k) + 41'sd16384;
      po_in   = po_prod[40:15];
      sum     = SUM_W'(x_ff) + SUM_W'(pp_ff) + SUM_W'(po_ff);
      out_in  = sat_st(sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff  <= '0;
         prev_ff <= '0;
         add_ff  <= 1'b0;
         go_ff   <= 1'b0;
      end else begin
         add_ff <= link_in.go;
         go_ff  <= add_ff;
         if (add_ff) begin
            out_ff  <= out_in;
            prev_ff <= x_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (link_in.go) begin
         pp_ff <= pp_in;
         po_ff <= po_in;
         x_ff  <= link_in.value;
      end
   end

   assign link_out = '{go: go_ff, value: out_ff};

endmodule

>>> sv/moog_ladder_lowpass_core.sv
// Top level of the four-pole resonant ladder lowpass: control, registers, cell chain.
// Depends on mll_pkg, mll_req_if, mll_rsp_if, mll_coef, mll_front and mll_cell.

// One signed Q1.15 word in gives one filtered Q1.15 word out, in order. After a word
// is accepted the block waits in the settle state for the coefficient pipeline, then
// passes the word through the input stage and the four ladder cells and loads the
// output register; a result that finds that register full waits in the fourth cell.
// The cell chain carries a single token, so the next word is taken only once the
// result is loaded, and is filtered while that result waits in the output register.
// Cutoff (Q0.15, byte address 0) and resonance (Q2.14, byte address 4) reset to 8192
// and 0. The user must write them over the APB-style port only while no word is in
// flight; the block itself does not enforce this.

module moog_ladder_lowpass_core (
   input  logic                                 clock,
   input  logic                                 reset,
   mll_req_if.sink                              req,
   mll_rsp_if.source                            rsp,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mll_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [mll_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [mll_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import mll_pkg::*;

   // Configuration registers.
   logic [CUT_W-1:0]          cutoff_ff;
   logic [RES_W-1:0]          resonance_ff;
   logic                      csr_write;
   csr_reg_type               csr_sel;

   // Control.
   ctrl_state_type            state_ff, state_in;
   logic [SETTLE_CNT_W-1:0]   settle_cnt_ff, settle_cnt_in;
   logic                      settle_done;
   logic                      chain_done;
   logic                      out_free;
   logic                      front_go;
   logic                      load_out;
   logic                      accept;

   // Datapath.
   logic signed [SMP_W-1:0]   sample_ff;
   coef_type                  coef;
   stage_link_type            link_chain [STAGES+1];
   logic signed [ST_W:0]      out_rnd;
   logic signed [SMP_W-1:0]   rsp_data_ff;
   logic                      rsp_valid_ff;

   // The register is chosen by address bit 2; the low byte-lane bits are ignored.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel    = csr_reg_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff    <= CUTOFF_RESET;
         resonance_ff <= RESONANCE_RESET;
      end else if (csr_write) begin
         case (csr_sel)
            CSR_CUTOFF: begin
               cutoff_ff <= csr_pwdata[CUT_W-1:0];
            end
            CSR_RESONANCE: begin
               resonance_ff <= csr_pwdata[RES_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         CSR_CUTOFF:    csr_prdata = CSR_DATA_W'(cutoff_ff);
         CSR_RESONANCE: csr_prdata = CSR_DATA_W'(resonance_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // Coefficients follow the registers through a four-level pipeline; the settle
   // wait below covers it even when a register was written on the accepting edge.
   mll_coef u_coef (
      .clock     (clock),
      .cutoff    (cutoff_ff),
      .resonance (resonance_ff),
      .coef      (coef)
   );

   // The input stage reads the fourth cell's last output as the feedback tap.
   mll_front u_front (
      .clock    (clock),
      .reset    (reset),
      .go       (front_go),
      .sample   (sample_ff),
      .fb_tap   (link_chain[STAGES].value),
      .coef     (coef),
      .link_out (link_chain[0])
   );

   // The ladder: each cell passes its new output and the token to the next one.
   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      mll_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .link_in  (link_chain[i]),
         .k        (coef.k),
         .link_out (link_chain[i+1])
      );
   end

   assign accept      = req.valid && req.ready;
   assign settle_done = (settle_cnt_ff == SETTLE_CNT_W'(SETTLE_CYCLES - 1));
   assign chain_done  = link_chain[STAGES].go;
   assign out_free    = !rsp_valid_ff || rsp.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            if (settle_done) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (chain_done) begin
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs. The fourth cell holds its output until the next word reaches
   // it, so a result parked in the hold state is still there when the register frees.
   always_comb begin
      req.ready     = 1'b0;
      front_go      = 1'b0;
      load_out      = 1'b0;
      settle_cnt_in = '0;
      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
         end
         ST_SETTLE: begin
            front_go      = settle_done;
            settle_cnt_in = settle_cnt_ff + 1'b1;
         end
         ST_RUN: begin
            load_out = chain_done && out_free;
         end
         ST_HOLD: begin
            load_out = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         settle_cnt_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         settle_cnt_ff <= settle_cnt_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Round the Q4.20 stage value to Q1.15 (halves up) and clamp it.
   assign out_rnd = (ST_W+1)'(link_chain[STAGES].value) + (ST_W+1)'(16);

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req.sample_in;
      end
      if (load_out) begin
         rsp_data_ff <= sat_out(out_rnd[ST_W:5]);
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.sample_out = rsp_data_ff;

endmodule
